### rtl/swb_pkg.sv
// Shared constants, types and status codes for the sample window bounds block.
package swb_pkg;

  localparam int LEN_BITS = 32;
  localparam int PROD_W   = 2 * LEN_BITS;
  localparam int DIV_STAGES = LEN_BITS;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int WORD_W = ADDR_W - 2;

  localparam logic [WORD_W-1:0] REG_CHECK_ENABLE = '0;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_CLIP   = 3'd1,
    ST_BADARG = 3'd2,
    ST_OVFL   = 3'd3,
    ST_INCONS = 3'd4
  } status_t;

  typedef struct packed {
    logic [LEN_BITS-1:0] srclen;
    logic [LEN_BITS-1:0] stp;
    logic [LEN_BITS-1:0] dstlen;
    logic [LEN_BITS-1:0] c0;
    logic [LEN_BITS-1:0] c0n;
    logic [LEN_BITS-1:0] so_raw;
    logic                lt;
    logic                badarg;
    logic                ovf1;
    logic                ovf2;
    logic                clip1;
    logic                clip2;
    logic                last;
  } meta_t;

endpackage

### rtl/swb_if.sv
// Request and result channel interfaces for the sample window bounds block.
interface swb_req_if import swb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEN_BITS-1:0] src_len;
  logic [LEN_BITS-1:0] step;
  logic [LEN_BITS-1:0] src_center;
  logic                src_center_given;
  logic [LEN_BITS-1:0] dst_len;
  logic [LEN_BITS-1:0] dst_center;
  logic                dst_center_given;
  logic                last_dimension;

  modport source (
    output valid, src_len, step, src_center, src_center_given,
           dst_len, dst_center, dst_center_given, last_dimension,
    input  ready
  );
  modport sink (
    input  valid, src_len, step, src_center, src_center_given,
           dst_len, dst_center, dst_center_given, last_dimension,
    output ready
  );
endinterface

interface swb_rsp_if import swb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEN_BITS-1:0] src_offset;
  logic [LEN_BITS-1:0] dst_offset;
  logic [LEN_BITS-1:0] dst_box;
  logic [2:0]          status;
  logic                last_dimension_out;

  modport source (
    output valid, src_offset, dst_offset, dst_box, status, last_dimension_out,
    input  ready
  );
  modport sink (
    input  valid, src_offset, dst_offset, dst_box, status, last_dimension_out,
    output ready
  );
endinterface

### rtl/swb_div.sv
// Pipelined restoring divider: two dividends over one divisor, one bit per stage.
module swb_div import swb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [LEN_BITS-1:0] dvd_a,
  input  logic [LEN_BITS-1:0] dvd_b,
  input  logic [LEN_BITS-1:0] dvs,
  input  meta_t               meta_in,
  output logic                out_valid,
  output logic [LEN_BITS-1:0] quo_a,
  output logic [LEN_BITS-1:0] quo_b,
  output logic [LEN_BITS-1:0] rem_b,
  output meta_t               meta_out
);

  function automatic logic [PROD_W-1:0] div_step(
    input logic [LEN_BITS-1:0] r,
    input logic [LEN_BITS-1:0] n,
    input logic [LEN_BITS-1:0] d
  );
    logic [LEN_BITS:0] trial;
    logic [LEN_BITS:0] diff;
    trial = {r, n[LEN_BITS-1]};
    diff  = trial - {1'b0, d};
    if (!diff[LEN_BITS]) begin
      return {diff[LEN_BITS-1:0], n[LEN_BITS-2:0], 1'b1};
    end
    return {trial[LEN_BITS-1:0], n[LEN_BITS-2:0], 1'b0};
  endfunction

  logic [LEN_BITS-1:0] ra  [DIV_STAGES];
  logic [LEN_BITS-1:0] na  [DIV_STAGES];
  logic [LEN_BITS-1:0] rb  [DIV_STAGES];
  logic [LEN_BITS-1:0] nb  [DIV_STAGES];
  meta_t               mt  [DIV_STAGES];
  logic                vld [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [LEN_BITS-1:0] ra_i, na_i, rb_i, nb_i, d_i;
    meta_t               m_i;
    logic                v_i;
    logic [PROD_W-1:0]   sa, sb;

    if (k == 0) begin : g_first
      assign ra_i = '0;
      assign na_i = dvd_a;
      assign rb_i = '0;
      assign nb_i = dvd_b;
      assign d_i  = dvs;
      assign m_i  = meta_in;
      assign v_i  = in_valid;
    end else begin : g_next
      assign ra_i = ra[k-1];
      assign na_i = na[k-1];
      assign rb_i = rb[k-1];
      assign nb_i = nb[k-1];
      assign d_i  = mt[k-1].stp;
      assign m_i  = mt[k-1];
      assign v_i  = vld[k-1];
    end

    assign sa = div_step(ra_i, na_i, d_i);
    assign sb = div_step(rb_i, nb_i, d_i);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ra[k] <= sa[PROD_W-1:LEN_BITS];
        na[k] <= sa[LEN_BITS-1:0];
        rb[k] <= sb[PROD_W-1:LEN_BITS];
        nb[k] <= sb[LEN_BITS-1:0];
        mt[k] <= m_i;
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quo_a     = na[DIV_STAGES-1];
  assign quo_b     = nb[DIV_STAGES-1];
  assign rem_b     = rb[DIV_STAGES-1];
  assign meta_out  = mt[DIV_STAGES-1];

endmodule

### rtl/sample_window_bounds.sv
// Top level: subsampling window bounds for one dimension per item.
//
//   channel  | kind         | handshake              | payload
//   ---------+--------------+------------------------+----------------------------------
//   req      | item in      | valid/ready            | lengths, step, centers, last flag
//   rsp      | item out     | valid/ready            | offsets, box, status, last flag
//   apb      | config write | psel/penable/pwrite    | check_enable at byte address 0
//
// One item enters per cycle while rsp is not stalled; each result passes stages A to C,
// the divider, stages E1 to E3 and the output register. The divider has 32 stages,
// one quotient bit per stage. Reset clears every stage valid bit and sets check_enable.
// A stall on rsp freezes the whole pipeline in place; req.ready drops with it.
module sample_window_bounds import swb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  swb_req_if.sink           req,
  swb_rsp_if.source         rsp
);

  logic check_enable;
  logic adv;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_CHECK_ENABLE) ? DATA_W'(check_enable) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_CHECK_ENABLE) begin
      check_enable <= pwdata[0];
    end
  end

  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // Stage A: pick centers, flag bad arguments
  logic [LEN_BITS-1:0] b0_in, c0_in;
  logic                a_v, a_badarg, a_last;
  logic [LEN_BITS-1:0] a_srclen, a_stp, a_dstlen, a_b0, a_c0, a_c0n;

  assign b0_in = req.src_center_given ? req.src_center : (req.src_len >> 1);
  assign c0_in = req.dst_center_given ? req.dst_center : (req.dst_len >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_srclen <= req.src_len;
      a_stp    <= req.step;
      a_dstlen <= req.dst_len;
      a_b0     <= b0_in;
      a_c0     <= c0_in;
      a_c0n    <= req.dst_len - c0_in;
      a_badarg <= (req.step == '0) ||
                  (req.dst_center_given && (req.dst_center >= req.dst_len));
      a_last   <= req.last_dimension;
    end
  end

  // Stage B: products and far-side distance
  logic                b_v, b_lt, b_badarg, b_last;
  logic [PROD_W-1:0]   b_p1, b_p2;
  logic [LEN_BITS-1:0] b_srclen, b_stp, b_dstlen, b_b0, b_c0, b_c0n, b_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_p1     <= PROD_W'(a_stp) * PROD_W'(a_c0);
      b_p2     <= PROD_W'(a_stp) * PROD_W'(a_c0n);
      b_lt     <= a_b0 < a_srclen;
      b_d2     <= (a_b0 < a_srclen) ? a_srclen - a_b0 : a_b0 - a_srclen;
      b_srclen <= a_srclen;
      b_stp    <= a_stp;
      b_dstlen <= a_dstlen;
      b_b0     <= a_b0;
      b_c0     <= a_c0;
      b_c0n    <= a_c0n;
      b_badarg <= a_badarg;
      b_last   <= a_last;
    end
  end

  // Stage C: overflow and clip flags, divider operands
  logic                c_v;
  logic [LEN_BITS-1:0] c_b0, c_d2;
  meta_t               c_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_b0       <= b_b0;
      c_d2       <= b_d2;
      c_m.srclen <= b_srclen;
      c_m.stp    <= b_stp;
      c_m.dstlen <= b_dstlen;
      c_m.c0     <= b_c0;
      c_m.c0n    <= b_c0n;
      c_m.so_raw <= b_b0 - b_p1[LEN_BITS-1:0];
      c_m.lt     <= b_lt;
      c_m.badarg <= b_badarg;
      c_m.ovf1   <= |b_p1[PROD_W-1:LEN_BITS];
      c_m.ovf2   <= |b_p2[PROD_W-1:LEN_BITS];
      c_m.clip1  <= b_p1[LEN_BITS-1:0] > b_b0;
      c_m.clip2  <= b_p2[LEN_BITS-1:0] > b_d2;
      c_m.last   <= b_last;
    end
  end

  logic                d_v;
  logic [LEN_BITS-1:0] d_q1, d_q2, d_r2;
  meta_t               d_m;

  swb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (c_v),
    .dvd_a     (c_b0),
    .dvd_b     (c_d2),
    .dvs       (c_m.stp),
    .meta_in   (c_m),
    .out_valid (d_v),
    .quo_a     (d_q1),
    .quo_b     (d_q2),
    .rem_b     (d_r2),
    .meta_out  (d_m)
  );

  // Stage E1: destination offset, far-side cut
  logic                e1_v, e1_rnz;
  logic [LEN_BITS-1:0] e1_offs, e1_c2, e1_q2;
  meta_t               e1_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
    end else if (adv) begin
      e1_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_m    <= d_m;
      e1_offs <= d_m.clip1 ? d_m.c0 - d_q1 : '0;
      e1_c2   <= d_m.c0n - d_q2;
      e1_q2   <= d_q2;
      e1_rnz  <= d_r2 != '0;
    end
  end

  // Stage E2: near-side box and test product
  logic                e2_v, e2_rnz;
  logic [LEN_BITS-1:0] e2_offs, e2_c2, e2_q2, e2_bx1, e2_m3;
  meta_t               e2_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_v <= 1'b0;
    end else if (adv) begin
      e2_v <= e1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_m    <= e1_m;
      e2_offs <= e1_offs;
      e2_c2   <= e1_c2;
      e2_q2   <= e1_q2;
      e2_rnz  <= e1_rnz;
      e2_bx1  <= e1_m.clip1 ? e1_m.dstlen - e1_offs : e1_m.dstlen;
      e2_m3   <= e1_m.stp * e1_offs;
    end
  end

  // Stage E3: far-side trims and consistency flags
  logic                e3_v, e3_rnz, e3_inc_lt, e3_inc_ge, e3_cond;
  logic [LEN_BITS-1:0] e3_offs, e3_q2, e3_bx_lt, e3_t;
  meta_t               e3_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      e3_v <= 1'b0;
    end else if (adv) begin
      e3_v <= e2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e3_m      <= e2_m;
      e3_offs   <= e2_offs;
      e3_q2     <= e2_q2;
      e3_rnz    <= e2_rnz;
      e3_bx_lt  <= e2_m.clip2 ? e2_bx1 - e2_c2 : e2_bx1;
      e3_inc_lt <= e2_m.clip2 && (e2_c2 > e2_bx1);
      e3_inc_ge <= e2_m.c0n > e2_bx1;
      e3_t      <= e2_bx1 - e2_m.c0n;
      e3_cond   <= e2_m3 < e2_m.srclen;
    end
  end

  // Output stage: resolve status, zero the window on error and src_offset on a near-side clip
  logic [LEN_BITS-1:0] bx_ge, bx_fin;
  logic                incons, clip, err;
  status_t             st;

  assign bx_ge  = e3_cond ? e3_t - e3_q2 - LEN_BITS'(e3_rnz) : '0;
  assign bx_fin = e3_m.lt ? e3_bx_lt : bx_ge;
  assign incons = check_enable && (e3_m.lt ? e3_inc_lt : e3_inc_ge);
  assign clip   = e3_m.clip1 || !e3_m.lt || e3_m.clip2;

  always_comb begin
    if (e3_m.badarg) begin
      st = ST_BADARG;
    end else if (e3_m.ovf1 || (e3_m.lt && e3_m.ovf2)) begin
      st = ST_OVFL;
    end else if (incons) begin
      st = ST_INCONS;
    end else if (clip) begin
      st = ST_CLIP;
    end else begin
      st = ST_OK;
    end
  end

  assign err = st inside {ST_BADARG, ST_OVFL, ST_INCONS};

  logic                o_v, o_last;
  logic [LEN_BITS-1:0] o_so, o_dof, o_box;
  status_t             o_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (adv) begin
      o_v <= e3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_so   <= (err || e3_m.clip1) ? '0 : e3_m.so_raw;
      o_dof  <= err ? '0 : e3_offs;
      o_box  <= err ? '0 : bx_fin;
      o_st   <= st;
      o_last <= e3_m.last;
    end
  end

  assign rsp.valid              = o_v;
  assign rsp.src_offset         = o_so;
  assign rsp.dst_offset         = o_dof;
  assign rsp.dst_box            = o_box;
  assign rsp.status             = o_st;
  assign rsp.last_dimension_out = o_last;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_BADARG || rsp.status == ST_OVFL ||
                  rsp.status == ST_INCONS)
    |-> rsp.src_offset == '0 && rsp.dst_offset == '0 && rsp.dst_box == '0)
    else $error("error status with nonzero window");

  a_dof_clip: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.dst_offset != '0 |-> rsp.status == ST_CLIP)
    else $error("destination offset without clip status");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> a_v == $past(a_v) && e3_v == $past(e3_v))
    else $error("pipeline valid moved during stall");

endmodule

### sim/testbench.sv
// Self-checking testbench for sample_window_bounds: random and directed items, live prediction.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import swb_pkg::*;

  localparam int          PIPE_LATENCY = 39;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          HOLD_AT      = 400;
  localparam int          HOLD_CYCLES  = 200;
  localparam logic [63:0] LEN_MASK     = 64'hFFFF_FFFF;
  localparam logic [31:0] MAXV         = 32'hFFFF_FFFF;
  localparam logic [ADDR_W-1:0] CHECK_ENABLE_ADDR = {REG_CHECK_ENABLE, 2'b00};

  typedef struct packed {
    logic [LEN_BITS-1:0] src_len;
    logic [LEN_BITS-1:0] step;
    logic [LEN_BITS-1:0] src_center;
    logic                src_center_given;
    logic [LEN_BITS-1:0] dst_len;
    logic [LEN_BITS-1:0] dst_center;
    logic                dst_center_given;
    logic                last_dimension;
  } dim_req_t;

  typedef struct packed {
    logic [LEN_BITS-1:0] src_offset;
    logic [LEN_BITS-1:0] dst_offset;
    logic [LEN_BITS-1:0] dst_box;
    status_t             status;
    logic                last;
  } window_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  swb_req_if req_ch ();
  swb_rsp_if rsp_ch ();

  sample_window_bounds uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  dim_req_t pending_dims[$];
  window_t  expected_windows[$];
  dim_req_t drive_item;
  window_t  want;

  bit check_on = 1'b1;
  bit req_took;
  bit rsp_took;
  bit send_burst;
  bit recv_burst;
  bit hold_done;
  int send_gap;
  int recv_gap;
  int hold_left;
  int errors;
  int items_taken;
  int results_seen;
  int cfg_writes;
  int cycle_count;
  int status_count[8];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic window_t window_bounds(input dim_req_t it, input bit chk);
    window_t     r;
    logic [63:0] srclen, stp, dstlen, b0, c0, cn, c1, offs, bx, rem_src, c2, over, so;
    r = '0;
    r.status = ST_OK;
    r.last = it.last_dimension;
    srclen = it.src_len;
    stp = it.step;
    dstlen = it.dst_len;
    if (stp == 0 || (it.dst_center_given && it.dst_center >= it.dst_len)) begin
      r.status = ST_BADARG;
      return r;
    end
    b0 = it.src_center_given ? 64'(it.src_center) : srclen / 2;
    c0 = it.dst_center_given ? 64'(it.dst_center) : dstlen / 2;
    c1 = stp * c0;
    if (c1 > LEN_MASK) begin
      r.status = ST_OVFL;
      return r;
    end
    if (c1 > b0) begin
      so = 0;
      offs = c0 - b0 / stp;
      bx = (dstlen - offs) & LEN_MASK;
      r.status = ST_CLIP;
    end else begin
      so = b0 - c1;
      offs = 0;
      bx = dstlen;
    end
    cn = dstlen - c0;
    if (b0 < srclen) begin
      rem_src = srclen - b0;
      c1 = stp * cn;
      if (c1 > LEN_MASK) begin
        r.status = ST_OVFL;
        return r;
      end
      if (c1 > rem_src) begin
        c2 = cn - rem_src / stp;
        if (chk && c2 > bx) begin
          r.status = ST_INCONS;
          return r;
        end
        bx = (bx - c2) & LEN_MASK;
        r.status = ST_CLIP;
      end
    end else begin
      if (chk && cn > bx) begin
        r.status = ST_INCONS;
        return r;
      end
      bx = (bx - cn) & LEN_MASK;
      if (((stp * offs) & LEN_MASK) < srclen) begin
        over = b0 - srclen;
        bx = (bx - over / stp) & LEN_MASK;
        if (over % stp != 0) bx = (bx - 1) & LEN_MASK;
      end else begin
        bx = 0;
      end
      r.status = ST_CLIP;
    end
    r.src_offset = so[31:0];
    r.dst_offset = offs[31:0];
    r.dst_box = bx[31:0];
    return r;
  endfunction

  function automatic dim_req_t mk_dim(input logic [31:0] sl, input logic [31:0] st,
                                      input logic [31:0] sc, input logic scg,
                                      input logic [31:0] dl, input logic [31:0] dc,
                                      input logic dcg, input logic last);
    dim_req_t d;
    d.src_len = sl;
    d.step = st;
    d.src_center = sc;
    d.src_center_given = scg;
    d.dst_len = dl;
    d.dst_center = dc;
    d.dst_center_given = dcg;
    d.last_dimension = last;
    return d;
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return MAXV;
      2, 3:    return $urandom;
      4:       return MAXV - $urandom_range(0, 64);
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 15))
      0:       return 32'd0;
      1:       return MAXV;
      2:       return $urandom;
      3:       return 32'd1 << $urandom_range(0, 31);
      4, 5:    return 32'd1;
      default: return $urandom_range(2, 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_center(input logic [31:0] len);
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return len;
      2:       return 32'd0;
      default: return (len == 0) ? 32'd0 : $urandom_range(0, len - 1);
    endcase
  endfunction

  function automatic dim_req_t rand_dim();
    dim_req_t d;
    d.src_len = rand_len();
    d.dst_len = rand_len();
    d.step = rand_step();
    d.src_center_given = 1'($urandom_range(0, 1));
    d.src_center = d.src_center_given ? rand_center(d.src_len) : $urandom;
    d.dst_center_given = 1'($urandom_range(0, 1));
    d.dst_center = d.dst_center_given ? rand_center(d.dst_len) : $urandom;
    d.last_dimension = 1'($urandom_range(0, 1));
    return d;
  endfunction

  task automatic cfg_write(input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CHECK_ENABLE_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_on = value[0];
    cfg_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_dims.size() != 0 || req_ch.valid || expected_windows.size() != 0)
      @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(negedge clk);
  endtask

  task automatic queue_random(input int count);
    repeat (count) pending_dims.push_back(rand_dim());
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_took) begin
      if (send_gap > 0) begin
        send_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_dims.size() != 0) begin
        drive_item = pending_dims.pop_front();
        req_ch.src_len <= drive_item.src_len;
        req_ch.step <= drive_item.step;
        req_ch.src_center <= drive_item.src_center;
        req_ch.src_center_given <= drive_item.src_center_given;
        req_ch.dst_len <= drive_item.dst_len;
        req_ch.dst_center <= drive_item.dst_center;
        req_ch.dst_center_given <= drive_item.dst_center_given;
        req_ch.last_dimension <= drive_item.last_dimension;
        req_ch.valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 3);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_took) begin
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    if (rst) begin
      req_took <= 1'b0;
      rsp_took <= 1'b0;
    end else begin
      req_took <= req_ch.valid && req_ch.ready;
      rsp_took <= rsp_ch.valid && rsp_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        expected_windows.push_back(window_bounds(mk_dim(req_ch.src_len, req_ch.step,
            req_ch.src_center, req_ch.src_center_given, req_ch.dst_len, req_ch.dst_center,
            req_ch.dst_center_given, req_ch.last_dimension), check_on));
        items_taken++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        status_count[rsp_ch.status]++;
        if (expected_windows.size() == 0) begin
          $error("unexpected result: no item outstanding");
          errors++;
        end else begin
          want = expected_windows.pop_front();
          if (rsp_ch.src_offset !== want.src_offset) begin
            $error("src_offset: expected %h, got %h", want.src_offset, rsp_ch.src_offset);
            errors++;
          end
          if (rsp_ch.dst_offset !== want.dst_offset) begin
            $error("dst_offset: expected %h, got %h", want.dst_offset, rsp_ch.dst_offset);
            errors++;
          end
          if (rsp_ch.dst_box !== want.dst_box) begin
            $error("dst_box: expected %h, got %h", want.dst_box, rsp_ch.dst_box);
            errors++;
          end
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            errors++;
          end
          if (rsp_ch.last_dimension_out !== want.last) begin
            $error("last_dimension_out: expected %b, got %b", want.last,
                   rsp_ch.last_dimension_out);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.src_len = '0;
    req_ch.step = '0;
    req_ch.src_center = '0;
    req_ch.src_center_given = 1'b0;
    req_ch.dst_len = '0;
    req_ch.dst_center = '0;
    req_ch.dst_center_given = 1'b0;
    req_ch.last_dimension = 1'b0;
    rsp_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: bad arguments, both overflow points, clipping on each side, box wrap
    pending_dims.push_back(mk_dim(32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0));
    pending_dims.push_back(mk_dim(MAXV, MAXV, MAXV, 1'b1, MAXV, MAXV, 1'b1, 1'b1));
    pending_dims.push_back(mk_dim(MAXV, 32'd1, MAXV, 1'b1, MAXV, MAXV - 1, 1'b1, 1'b1));
    pending_dims.push_back(mk_dim(32'd8, 32'd1, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1, 1'b0));
    pending_dims.push_back(mk_dim(32'd100, 32'd2, 32'd0, 1'b0, 32'd10, 32'd11, 1'b1, 1'b0));
    pending_dims.push_back(mk_dim(32'd100, MAXV, 32'd0, 1'b0, 32'd4, 32'd0, 1'b0, 1'b0));
    pending_dims.push_back(mk_dim(MAXV, 32'h10000, 32'd0, 1'b1, 32'h10000, 32'd0, 1'b1, 1'b0));
    pending_dims.push_back(mk_dim(32'd1000, 32'd4, 32'd0, 1'b0, 32'd200, 32'd0, 1'b0, 1'b0));
    pending_dims.push_back(mk_dim(32'd100, 32'd3, 32'd10, 1'b1, 32'd100, 32'd0, 1'b0, 1'b0));
    pending_dims.push_back(mk_dim(32'd10, 32'd1, 32'd100, 1'b1, 32'd10, 32'd0, 1'b0, 1'b1));
    pending_dims.push_back(mk_dim(32'd10, 32'd7, 32'd200, 1'b1, 32'd50, 32'd3, 1'b1, 1'b0));
    pending_dims.push_back(mk_dim(32'd64, 32'd1, 32'd0, 1'b0, 32'd64, 32'd0, 1'b0, 1'b0));
    pending_dims.push_back(mk_dim(MAXV, MAXV, 32'd0, 1'b0, 32'd1, 32'd0, 1'b0, 1'b1));
    pending_dims.push_back(mk_dim(32'd1, 32'd1, 32'd0, 1'b0, 32'd1000, 32'd0, 1'b0, 1'b0));
    pending_dims.push_back(mk_dim(32'd50, 32'd5, 32'd0, 1'b1, 32'd20, 32'd0, 1'b1, 1'b0));
    pending_dims.push_back(mk_dim(MAXV, 32'd2, MAXV, 1'b1, 32'd1000, 32'd999, 1'b1, 1'b1));
    pending_dims.push_back(mk_dim(32'h80000000, 32'h80000000, 32'd0, 1'b0, 32'd3, 32'd0,
                                  1'b0, 1'b0));
    pending_dims.push_back(mk_dim(32'd16, 32'd1, 32'd0, 1'b0, MAXV, 32'd0, 1'b0, 1'b0));
    wait_drained();

    cfg_write(32'd0);
    queue_random(360);
    wait_drained();
    cfg_write(32'd1);
    queue_random(360);
    wait_drained();
    cfg_write(32'd0);
    queue_random(360);
    wait_drained();
    cfg_write(32'd1);
    queue_random(370);
    wait_drained();

    if (expected_windows.size() != 0) begin
      $error("%0d results never arrived", expected_windows.size());
      errors++;
    end
    $display("items %0d, results %0d, check_enable writes %0d, long result stall %0d cycles",
             items_taken, results_seen, cfg_writes, HOLD_CYCLES);
    $display("status mix: ok %0d, clipped %0d, bad arg %0d, overflow %0d, inconsistent %0d",
             status_count[ST_OK], status_count[ST_CLIP], status_count[ST_BADARG],
             status_count[ST_OVFL], status_count[ST_INCONS]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
